>>> design/slts_pkg.sv
package slts_pkg;

    localparam int OP_W     = 3;
    localparam int SLOT_W   = 11;
    localparam int ESLOT_W  = 15;
    localparam int ROW_W    = 10;
    localparam int DATA_W   = 32;
    localparam int ROWCNT_W = 11;
    localparam int PROD_W   = 2 * DATA_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // operation codes of the input item
    localparam logic [OP_W-1:0] OP_COL_START = 3'd0;
    localparam logic [OP_W-1:0] OP_ENTRY     = 3'd1;
    localparam logic [OP_W-1:0] OP_INV_DIAG  = 3'd2;
    localparam logic [OP_W-1:0] OP_PERM      = 3'd3;
    localparam logic [OP_W-1:0] OP_RHS       = 3'd4;
    localparam logic [OP_W-1:0] OP_READ      = 3'd5;

    typedef enum logic [2:0] {
        K_COL_START,
        K_ENTRY,
        K_INV_DIAG,
        K_PERM,
        K_RHS,
        K_READ
    } t_kind;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic [SLOT_W-1:0]         slot;
        logic [ESLOT_W-1:0]        entry_slot;
        logic [ROW_W-1:0]          row_index;
        logic signed [DATA_W-1:0]  value;
        logic                      start_req;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]          solution_index;
        logic signed [DATA_W-1:0]  solution;
        logic                      saturated;
    } t_out_item;

    // classified command passed from front to back
    typedef struct packed {
        t_kind                     kind;
        logic [SLOT_W-1:0]         slot;
        logic [ESLOT_W-1:0]        entry_slot;
        logic [ROW_W-1:0]          row_index;
        logic signed [DATA_W-1:0]  value;
        logic                      start;
        logic                      in_range;
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RHS,
        S_RD_P,
        S_RD_W,
        S_F_COL,
        S_F_HDR,
        S_F_ENT,
        S_F_CHK,
        S_F_UPD,
        S_S_RD,
        S_S_MUL,
        S_S_WR,
        S_B_COL,
        S_B_HDR,
        S_B_ENT,
        S_B_CHK,
        S_B_MUL,
        S_B_UPD
    } t_state;

endpackage

>>> design/slts_front.sv
module slts_front #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_ENTRIES = 16384
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  slts_pkg::t_in_item i_in_data,
    output logic               o_cmd_valid,
    input  logic               i_cmd_ready,
    output slts_pkg::t_cmd     o_cmd
);

    logic           r_valid;
    slts_pkg::t_cmd r_cmd;
    slts_pkg::t_cmd cmd;
    logic           keep;
    logic           rows_ok;
    logic           cols_ok;
    logic           ent_ok;
    logic           accept;

    assign rows_ok = 32'(i_in_data.slot) < 32'(MAX_ROWS);
    assign cols_ok = 32'(i_in_data.slot) <= 32'(MAX_ROWS);
    assign ent_ok  = 32'(i_in_data.entry_slot) < 32'(MAX_ENTRIES);

    // decode and range check, out-of-range writes and unused codes are dropped here
    always_comb begin
        cmd.kind       = slts_pkg::K_READ;
        cmd.slot       = i_in_data.slot;
        cmd.entry_slot = i_in_data.entry_slot;
        cmd.row_index  = i_in_data.row_index;
        cmd.value      = i_in_data.value;
        cmd.start      = i_in_data.start_req;
        cmd.in_range   = rows_ok;
        keep           = 1'b0;
        case (i_in_data.operation)
            slts_pkg::OP_COL_START: begin
                cmd.kind = slts_pkg::K_COL_START;
                keep     = cols_ok;
            end
            slts_pkg::OP_ENTRY: begin
                cmd.kind = slts_pkg::K_ENTRY;
                keep     = ent_ok;
            end
            slts_pkg::OP_INV_DIAG: begin
                cmd.kind = slts_pkg::K_INV_DIAG;
                keep     = rows_ok;
            end
            slts_pkg::OP_PERM: begin
                cmd.kind = slts_pkg::K_PERM;
                keep     = rows_ok;
            end
            slts_pkg::OP_RHS: begin
                cmd.kind = slts_pkg::K_RHS;
                keep     = rows_ok || i_in_data.start_req;
            end
            slts_pkg::OP_READ: begin
                cmd.kind = slts_pkg::K_READ;
                keep     = rows_ok;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_in_ready  = !r_valid || i_cmd_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= keep;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= cmd;
        end
    end

endmodule

>>> design/slts_queue.sv
module slts_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  slts_pkg::t_cmd i_push_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output slts_pkg::t_cmd o_pop_data
);

    slts_pkg::t_cmd                r_mem [slts_pkg::QUEUE_DEPTH];
    logic [slts_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [slts_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [slts_pkg::QPTR_W:0]     r_count;
    logic                          push;
    logic                          pop;

    assign o_push_ready = r_count != (slts_pkg::QPTR_W + 1)'(slts_pkg::QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

>>> design/slts_back.sv
module slts_back #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_ENTRIES = 16384,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [slts_pkg::ROWCNT_W-1:0]    i_cfg_data,
    input  logic                             i_cmd_valid,
    output logic                             o_cmd_ready,
    input  slts_pkg::t_cmd                   i_cmd,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output slts_pkg::t_out_item              o_out_data
);

    localparam int AW   = $clog2(MAX_ROWS);
    localparam int CW   = $clog2(MAX_ROWS + 1);
    localparam int EAW  = $clog2(MAX_ENTRIES);
    localparam int EXW  = (slts_pkg::ESLOT_W > EAW + 1) ? slts_pkg::ESLOT_W : EAW + 1;
    localparam int SATB = (VALUE_WIDTH < slts_pkg::DATA_W) ? VALUE_WIDTH : slts_pkg::DATA_W;
    localparam logic signed [slts_pkg::PROD_W-1:0] VMAX =
        (64'sd1 <<< (SATB - 1)) - 64'sd1;
    localparam logic signed [slts_pkg::PROD_W-1:0] VMIN = -VMAX - 64'sd1;
    localparam int DW = slts_pkg::DATA_W;
    localparam int PW = slts_pkg::PROD_W;

    // stores
    logic [slts_pkg::ESLOT_W-1:0] mem_cs [MAX_ROWS + 1];
    logic [slts_pkg::ROW_W-1:0]   mem_er [MAX_ENTRIES];
    logic signed [DW-1:0]         mem_ev [MAX_ENTRIES];
    logic signed [DW-1:0]         mem_id [MAX_ROWS];
    logic [slts_pkg::ROW_W-1:0]   mem_pp [MAX_ROWS];
    logic signed [DW-1:0]         mem_wk [MAX_ROWS];

    logic [slts_pkg::ESLOT_W-1:0] cs_lo_q;
    logic [slts_pkg::ESLOT_W-1:0] cs_hi_q;
    logic [slts_pkg::ROW_W-1:0]   er_q;
    logic signed [DW-1:0]         ev_q;
    logic signed [DW-1:0]         id_q;
    logic [slts_pkg::ROW_W-1:0]   pp_q;
    logic signed [DW-1:0]         wk_q;

    logic                         cs_we;
    logic [CW-1:0]                cs_wa;
    logic [CW-1:0]                cs_ra0;
    logic [CW-1:0]                cs_ra1;
    logic                         ent_we;
    logic [EAW-1:0]               ent_wa;
    logic                         id_we;
    logic                         pp_we;
    logic [AW-1:0]                slot_a;
    logic                         wk_we;
    logic [AW-1:0]                wk_wa;
    logic signed [DW-1:0]         wk_wd;
    logic [AW-1:0]                wk_ra;

    // registers
    slts_pkg::t_state             r_state;
    slts_pkg::t_state             n_state;
    logic [CW-1:0]                r_j, n_j;
    logic [CW-1:0]                r_n, n_n;
    logic [EXW-1:0]               r_e, n_e;
    logic [EXW-1:0]               r_hi, n_hi;
    logic [AW-1:0]                r_i, n_i;
    logic signed [DW-1:0]         r_y, n_y;
    logic signed [DW-1:0]         r_s, n_s;
    logic [slts_pkg::ROW_W-1:0]   r_p, n_p;
    slts_pkg::t_cmd               r_cmd, n_cmd;
    logic signed [PW-1:0]         r_prod, n_prod;
    logic                         r_ovf, n_ovf;
    logic [slts_pkg::ROWCNT_W-1:0] r_row_count;
    logic                         r_out_valid, n_out_valid;
    slts_pkg::t_out_item          r_out, n_out;

    // index helpers
    logic [31:0]                  slot_x;
    logic [31:0]                  eslot_x;
    logic [31:0]                  pp_x;
    logic [31:0]                  rp_x;
    logic [31:0]                  ei_x;
    logic [31:0]                  lo_x;
    logic [31:0]                  hi_raw_x;
    logic [31:0]                  hi_x;
    logic [31:0]                  rc_x;
    logic [31:0]                  nn_x;
    logic [CW-1:0]                j_inc;
    logic [CW-1:0]                c_idx;
    logic                         row_below_j;
    logic                         row_below_c;

    // arithmetic
    logic signed [PW-1:0]         prod_rnd;
    logic signed [PW-1:0]         sat_in;
    logic signed [DW-1:0]         sat_out;
    logic                         sat_hit;
    logic signed [DW-1:0]         mul_a;
    logic signed [DW-1:0]         mul_b;

    assign slot_x   = 32'(i_cmd.slot);
    assign eslot_x  = 32'(i_cmd.entry_slot);
    assign pp_x     = 32'(pp_q);
    assign rp_x     = 32'(r_p);
    assign ei_x     = 32'(er_q);
    assign lo_x     = 32'(cs_lo_q);
    assign hi_raw_x = 32'(cs_hi_q);
    assign hi_x     = (hi_raw_x > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : hi_raw_x;
    assign rc_x     = 32'(r_row_count);
    assign nn_x     = (rc_x > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : rc_x;
    assign j_inc    = r_j + CW'(1);
    assign c_idx    = r_j - CW'(1);
    assign slot_a   = slot_x[AW-1:0];
    assign ent_wa   = eslot_x[EAW-1:0];

    // only strictly lower entries inside the active system take part
    assign row_below_j = (ei_x > 32'(r_j)) && (ei_x < 32'(r_n));
    assign row_below_c = (ei_x > 32'(c_idx)) && (ei_x < 32'(r_n));

    assign prod_rnd = (r_prod + 64'sd32768) >>> 16;
    assign sat_hit  = (sat_in > VMAX) || (sat_in < VMIN);
    assign sat_out  = (sat_in > VMAX) ? VMAX[DW-1:0] :
                      (sat_in < VMIN) ? VMIN[DW-1:0] : sat_in[DW-1:0];

    always_comb begin
        case (r_state)
            slts_pkg::S_F_UPD: sat_in = PW'(wk_q) - prod_rnd;
            slts_pkg::S_B_UPD: sat_in = PW'(r_s) - prod_rnd;
            default:           sat_in = prod_rnd;
        endcase
    end

    always_comb begin
        case (r_state)
            slts_pkg::S_S_MUL: begin
                mul_a = wk_q;
                mul_b = id_q;
            end
            slts_pkg::S_B_MUL: begin
                mul_a = ev_q;
                mul_b = wk_q;
            end
            default: begin
                mul_a = ev_q;
                mul_b = r_y;
            end
        endcase
    end

    assign n_prod = mul_a * mul_b;

    // read addresses, held in the states that wait on the data
    assign cs_ra0 = (r_state == slts_pkg::S_B_COL) ? c_idx : r_j;
    assign cs_ra1 = (r_state == slts_pkg::S_B_COL) ? r_j : j_inc;

    always_comb begin
        case (r_state)
            slts_pkg::S_B_COL: wk_ra = c_idx[AW-1:0];
            slts_pkg::S_F_CHK,
            slts_pkg::S_B_CHK: wk_ra = ei_x[AW-1:0];
            slts_pkg::S_RD_P:  wk_ra = pp_x[AW-1:0];
            slts_pkg::S_RD_W:  wk_ra = rp_x[AW-1:0];
            default:           wk_ra = r_j[AW-1:0];
        endcase
    end

    assign o_cmd_ready = r_state == slts_pkg::S_IDLE;

    always_comb begin
        n_state     = r_state;
        n_j         = r_j;
        n_n         = r_n;
        n_e         = r_e;
        n_hi        = r_hi;
        n_i         = r_i;
        n_y         = r_y;
        n_s         = r_s;
        n_p         = r_p;
        n_cmd       = r_cmd;
        n_ovf       = r_ovf;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        cs_we       = 1'b0;
        cs_wa       = slot_x[CW-1:0];
        ent_we      = 1'b0;
        id_we       = 1'b0;
        pp_we       = 1'b0;
        wk_we       = 1'b0;
        wk_wa       = r_j[AW-1:0];
        wk_wd       = sat_out;
        case (r_state)
            slts_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    case (i_cmd.kind)
                        slts_pkg::K_COL_START: cs_we  = 1'b1;
                        slts_pkg::K_ENTRY:     ent_we = 1'b1;
                        slts_pkg::K_INV_DIAG:  id_we  = 1'b1;
                        slts_pkg::K_PERM:      pp_we  = 1'b1;
                        slts_pkg::K_RHS:       n_state = slts_pkg::S_RHS;
                        slts_pkg::K_READ:      n_state = slts_pkg::S_RD_P;
                        default:               n_state = slts_pkg::S_IDLE;
                    endcase
                end
            end
            slts_pkg::S_RHS: begin
                // permuted position is in pp_q now
                wk_wa = pp_x[AW-1:0];
                wk_wd = r_cmd.value;
                wk_we = r_cmd.in_range && (pp_x < 32'(MAX_ROWS));
                if (r_cmd.start) begin
                    n_ovf   = 1'b0;
                    n_n     = nn_x[CW-1:0];
                    n_j     = '0;
                    n_state = slts_pkg::S_F_COL;
                end else begin
                    n_state = slts_pkg::S_IDLE;
                end
            end
            slts_pkg::S_RD_P: begin
                n_p     = pp_q;
                n_state = slts_pkg::S_RD_W;
            end
            slts_pkg::S_RD_W: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.solution_index = r_cmd.slot[slts_pkg::ROW_W-1:0];
                    n_out.solution       = (rp_x < 32'(MAX_ROWS)) ? wk_q : '0;
                    n_out.saturated      = r_ovf;
                    n_out_valid          = 1'b1;
                    n_state              = slts_pkg::S_IDLE;
                end
            end
            // forward substitution, scatter form
            slts_pkg::S_F_COL: begin
                n_state = (r_j == r_n) ? slts_pkg::S_S_RD : slts_pkg::S_F_HDR;
                if (r_j == r_n) begin
                    n_j = '0;
                end
            end
            slts_pkg::S_F_HDR: begin
                n_y     = wk_q;
                n_e     = lo_x[EXW-1:0];
                n_hi    = hi_x[EXW-1:0];
                n_state = slts_pkg::S_F_ENT;
            end
            slts_pkg::S_F_ENT: begin
                if (r_e >= r_hi) begin
                    n_j     = j_inc;
                    n_state = slts_pkg::S_F_COL;
                end else begin
                    n_state = slts_pkg::S_F_CHK;
                end
            end
            slts_pkg::S_F_CHK: begin
                if (row_below_j) begin
                    n_i     = ei_x[AW-1:0];
                    n_state = slts_pkg::S_F_UPD;
                end else begin
                    n_e     = r_e + EXW'(1);
                    n_state = slts_pkg::S_F_ENT;
                end
            end
            slts_pkg::S_F_UPD: begin
                wk_we   = 1'b1;
                wk_wa   = r_i;
                n_ovf   = r_ovf || sat_hit;
                n_e     = r_e + EXW'(1);
                n_state = slts_pkg::S_F_ENT;
            end
            // diagonal scaling
            slts_pkg::S_S_RD: begin
                if (r_j == r_n) begin
                    n_state = slts_pkg::S_B_COL;
                end else begin
                    n_state = slts_pkg::S_S_MUL;
                end
            end
            slts_pkg::S_S_MUL: begin
                n_state = slts_pkg::S_S_WR;
            end
            slts_pkg::S_S_WR: begin
                wk_we   = 1'b1;
                n_ovf   = r_ovf || sat_hit;
                n_j     = j_inc;
                n_state = slts_pkg::S_S_RD;
            end
            // back substitution, column scan with falling column
            slts_pkg::S_B_COL: begin
                n_state = (r_j == '0) ? slts_pkg::S_IDLE : slts_pkg::S_B_HDR;
            end
            slts_pkg::S_B_HDR: begin
                n_s     = wk_q;
                n_e     = lo_x[EXW-1:0];
                n_hi    = hi_x[EXW-1:0];
                n_state = slts_pkg::S_B_ENT;
            end
            slts_pkg::S_B_ENT: begin
                if (r_e >= r_hi) begin
                    wk_we   = 1'b1;
                    wk_wa   = c_idx[AW-1:0];
                    wk_wd   = r_s;
                    n_j     = c_idx;
                    n_state = slts_pkg::S_B_COL;
                end else begin
                    n_state = slts_pkg::S_B_CHK;
                end
            end
            slts_pkg::S_B_CHK: begin
                if (row_below_c) begin
                    n_i     = ei_x[AW-1:0];
                    n_state = slts_pkg::S_B_MUL;
                end else begin
                    n_e     = r_e + EXW'(1);
                    n_state = slts_pkg::S_B_ENT;
                end
            end
            slts_pkg::S_B_MUL: begin
                n_state = slts_pkg::S_B_UPD;
            end
            slts_pkg::S_B_UPD: begin
                n_s     = sat_out;
                n_ovf   = r_ovf || sat_hit;
                n_e     = r_e + EXW'(1);
                n_state = slts_pkg::S_B_ENT;
            end
            default: begin
                n_state = slts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_row_count <= slts_pkg::ROWCNT_W'(1);
        end else begin
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_row_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j    <= n_j;
        r_n    <= n_n;
        r_e    <= n_e;
        r_hi   <= n_hi;
        r_i    <= n_i;
        r_y    <= n_y;
        r_s    <= n_s;
        r_p    <= n_p;
        r_cmd  <= n_cmd;
        r_prod <= n_prod;
        r_out  <= n_out;
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (cs_we) begin
            mem_cs[cs_wa] <= i_cmd.entry_slot;
        end
        cs_lo_q <= mem_cs[cs_ra0];
        cs_hi_q <= mem_cs[cs_ra1];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            mem_er[ent_wa] <= i_cmd.row_index;
            mem_ev[ent_wa] <= i_cmd.value;
        end
        er_q <= mem_er[r_e[EAW-1:0]];
        ev_q <= mem_ev[r_e[EAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (id_we) begin
            mem_id[slot_a] <= i_cmd.value;
        end
        id_q <= mem_id[r_j[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (pp_we) begin
            mem_pp[slot_a] <= i_cmd.row_index;
        end
        pp_q <= mem_pp[slot_a];
    end

    always_ff @(posedge i_clk) begin
        if (wk_we) begin
            mem_wk[wk_wa] <= wk_wd;
        end
        wk_q <= mem_wk[wk_ra];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_upd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slts_pkg::S_F_UPD) |-> (32'(r_i) < 32'(r_n)))
        else $error("forward update row outside the active system");

    a_solve_clears_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slts_pkg::S_RHS && r_cmd.start)
            |=> (!r_ovf && r_state == slts_pkg::S_F_COL))
        else $error("solve start did not clear the saturation flag");

    a_read_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slts_pkg::S_RD_W && r_out_valid && !i_out_ready)
            |=> (r_state == slts_pkg::S_RD_W))
        else $error("read result overwrote a pending output");

endmodule

>>> design/sparse_ldlt_triangular_solve.sv
// Sparse LDL^T triangular solve on Q16.16 values. Load the unit lower factor in
// compressed-column form (column starts, entries), the inverse diagonal and the
// permutation, then send rhs elements by original index; the element carrying
// start_req runs forward substitution, diagonal scaling and back substitution in
// place, and solutions are read back by original index together with a sticky
// saturation flag that is cleared at each solve start. Items enter through a
// register stage that decodes and range-checks them and drops those with no
// effect, then wait in a four-entry queue for the execution sequencer, so the
// input keeps flowing while a result waits at the output register, until the
// queue fills. A read is held in the sequencer while the output stalls, and
// every forward and backward update of a solve goes through the single read
// port on the work store. Configuration writes of row_count are always taken
// and must only be issued while the block is idle.
module sparse_ldlt_triangular_solve #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_ENTRIES = 16384,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input item channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  slts_pkg::t_in_item            i_in_data,
    // result channel, one transaction per read
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output slts_pkg::t_out_item           o_out_data,
    // row_count register write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [slts_pkg::ROWCNT_W-1:0] i_cfg_data
);

    logic           front_valid;
    logic           front_ready;
    slts_pkg::t_cmd front_cmd;
    logic           queue_valid;
    logic           queue_ready;
    slts_pkg::t_cmd queue_cmd;

    // register write is accepted in any cycle
    assign o_cfg_ready = 1'b1;

    // decode and drop items that have no effect
    slts_front #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    // decouples the front from a long-running solve
    slts_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_cmd),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_data   (queue_cmd)
    );

    // stores, solve sequencer and output register
    slts_back #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_ENTRIES (MAX_ENTRIES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (queue_valid),
        .o_cmd_ready (queue_ready),
        .i_cmd       (queue_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
